@@ src/cvm_pkg.sv @@
// shared widths, register codes and pipeline types for the tap valid mask block
package cvm_pkg;

    // lane and field widths
    localparam int LANES      = 32;
    localparam int LANE_W     = $clog2(LANES);
    localparam int DIM_W      = 12;
    localparam int NIB_W      = 4;
    localparam int BLOCK_W    = 19;
    localparam int TAP_W      = 4;
    localparam int POS_W      = BLOCK_W + LANE_W;
    localparam int MAX_TAPS   = 16;

    // tap offset: tap * dilation - pad, from -15 to 225
    localparam int OFF_W      = 2 * NIB_W + 1;
    // input row coordinate: position row * stride + offset
    localparam int H_W        = POS_W + NIB_W + 2;
    // input column coordinate: column * stride + offset
    localparam int W_W        = DIM_W + NIB_W + 2;

    // long division of the block base by the output width
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = POS_W / DIV_PER_STAGE;
    // per lane quotient bits once the lane index is added to the base remainder
    localparam int LANE_Q_W      = LANE_W;
    localparam int LANE_Q_HI     = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DILATION   = 3'd6;

    // per word context that travels down the pipeline
    typedef struct packed {
        logic [POS_W-1:0]        base;
        logic [POS_W-1:0]        total;
        logic signed [OFF_W-1:0] off_h;
        logic signed [OFF_W-1:0] off_w;
        logic                    kill;
    } t_ctx;

endpackage

@@ src/conv_tap_valid_mask.sv @@
// convolution tap validity mask: one 32-lane mask per word, deep pipeline
//
// input channel: i_valid / o_stall with i_block_index, i_tap_row, i_tap_col;
// a word is taken at a clock edge where i_valid is high and o_stall is low
// output channel: o_valid / i_stall with o_valid_mask; a word leaves at an
// edge where o_valid is high and i_stall is low
// configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high, writes belong in idle periods only
//
// from input to output: one input stage, six stages of the block base /
// output width long division (4 quotient bits each), then lane split,
// lane coordinate, multiply by stride and bounds compare stages
// throughput is one word per cycle while i_stall is low; each stage holds
// its own valid bit so bubbles close up while the output is stalled, and
// o_stall rises only when every stage holds a word and the receiver stalls
// reset (synchronous, active low) empties the pipeline and loads the
// defaults: all sizes 1, strides and dilations 1, padding 0
module conv_tap_valid_mask import cvm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BLOCK_W-1:0]    i_block_index,
    input  logic [TAP_W-1:0]      i_tap_row,
    input  logic [TAP_W-1:0]      i_tap_col,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [LANES-1:0]      o_valid_mask,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ST_DIV0 = 1;
    localparam int ST_LA   = 1 + DIV_STAGES;
    localparam int ST_LB   = ST_LA + 1;
    localparam int ST_LC   = ST_LB + 1;
    localparam int ST_LD   = ST_LC + 1;
    localparam int NSTG    = ST_LD + 1;

    // configuration registers
    logic [DIM_W-1:0] r_in_h, r_in_w, r_out_h, r_out_w;
    logic [7:0]       r_stride, r_pad, r_dil;

    // per stage valid bits and advance enables
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] adv;

    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_h   <= DIM_W'(1);
            r_in_w   <= DIM_W'(1);
            r_out_h  <= DIM_W'(1);
            r_out_w  <= DIM_W'(1);
            r_stride <= 8'h11;
            r_pad    <= 8'h00;
            r_dil    <= 8'h11;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_IN_HEIGHT:  r_in_h   <= i_cfg_data;
                REG_IN_WIDTH:   r_in_w   <= i_cfg_data;
                REG_OUT_HEIGHT: r_out_h  <= i_cfg_data;
                REG_OUT_WIDTH:  r_out_w  <= i_cfg_data;
                REG_STRIDE:     r_stride <= i_cfg_data[7:0];
                REG_PAD:        r_pad    <= i_cfg_data[7:0];
                REG_DILATION:   r_dil    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    assign adv[NSTG-1] = !r_v[NSTG-1] || !i_stall;
    genvar gs;
    for (gs = 0; gs < NSTG - 1; gs++) begin : g_adv
        assign adv[gs] = !r_v[gs] || adv[gs+1];
    end

    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // input stage: block base, map size and tap offsets
    t_ctx                r_ctx0;
    t_ctx                n_ctx0;
    logic [2*NIB_W-1:0]  tap_h_prod, tap_w_prod;

    always_comb begin
        tap_h_prod   = {{NIB_W{1'b0}}, i_tap_row} * {{NIB_W{1'b0}}, r_dil[7:4]};
        tap_w_prod   = {{NIB_W{1'b0}}, i_tap_col} * {{NIB_W{1'b0}}, r_dil[3:0]};
        n_ctx0.base  = {i_block_index, LANE_W'(0)};
        n_ctx0.total = POS_W'(r_out_h) * POS_W'(r_out_w);
        n_ctx0.off_h = $signed({1'b0, tap_h_prod}) - $signed({{(OFF_W-NIB_W){1'b0}}, r_pad[7:4]});
        n_ctx0.off_w = $signed({1'b0, tap_w_prod}) - $signed({{(OFF_W-NIB_W){1'b0}}, r_pad[3:0]});
        n_ctx0.kill  = ({1'b0, i_tap_row} >= (TAP_W+1)'(MAX_TAPS))
                    || ({1'b0, i_tap_col} >= (TAP_W+1)'(MAX_TAPS));
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_ctx0 <= n_ctx0;
        end
    end

    // long division of the block base by the output width, 4 bits per stage
    logic [DIM_W-1:0] r_div_rem [DIV_STAGES];
    logic [POS_W-1:0] r_div_quo [DIV_STAGES];
    t_ctx             r_div_ctx [DIV_STAGES];

    genvar gd;
    for (gd = 0; gd < DIV_STAGES; gd++) begin : g_div
        logic [DIM_W-1:0] rem_in, n_rem;
        logic [POS_W-1:0] quo_in, n_quo;
        t_ctx             ctx_in;

        if (gd == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign ctx_in = r_ctx0;
        end else begin : g_next
            assign rem_in = r_div_rem[gd-1];
            assign quo_in = r_div_quo[gd-1];
            assign ctx_in = r_div_ctx[gd-1];
        end

        // restoring steps, most significant quotient bit first
        always_comb begin
            logic [DIM_W:0] t;
            n_rem = rem_in;
            n_quo = quo_in;
            t     = '0;
            for (int s = 0; s < DIV_PER_STAGE; s++) begin
                t = {n_rem, ctx_in.base[POS_W-1-(gd*DIV_PER_STAGE+s)]};
                if (t >= {1'b0, r_out_w}) begin
                    t = t - {1'b0, r_out_w};
                    n_quo[POS_W-1-(gd*DIV_PER_STAGE+s)] = 1'b1;
                end
                n_rem = t[DIM_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv[ST_DIV0+gd]) begin
                r_div_rem[gd] <= n_rem;
                r_div_quo[gd] <= n_quo;
                r_div_ctx[gd] <= ctx_in;
            end
        end
    end

    // lane split, upper quotient bits of (base remainder + lane) / width
    logic [DIM_W:0]               r_la_v [LANES];
    logic [LANE_Q_W-LANE_Q_HI-1:0] r_la_k [LANES];
    logic [POS_W-1:0]             r_la_p0;
    t_ctx                         r_la_ctx;
    logic [DIM_W:0]               n_la_v [LANES];
    logic [LANE_Q_W-LANE_Q_HI-1:0] n_la_k [LANES];

    always_comb begin
        logic [DIM_W:0] v;
        v = '0;
        for (int i = 0; i < LANES; i++) begin
            v = {1'b0, r_div_rem[DIV_STAGES-1]} + (DIM_W+1)'(i);
            n_la_k[i] = '0;
            for (int j = LANE_Q_W - 1; j >= LANE_Q_W - LANE_Q_HI + 1; j--) begin
                if ({{LANE_Q_W{1'b0}}, v} >= ({{(LANE_Q_W+1){1'b0}}, r_out_w} << j)) begin
                    v = v - (DIM_W+1)'({{(LANE_Q_W+1){1'b0}}, r_out_w} << j);
                    n_la_k[i][j-(LANE_Q_W-LANE_Q_HI+1)] = 1'b1;
                end
            end
            n_la_v[i] = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_LA]) begin
            r_la_v   <= n_la_v;
            r_la_k   <= n_la_k;
            r_la_p0  <= r_div_quo[DIV_STAGES-1];
            r_la_ctx <= r_div_ctx[DIV_STAGES-1];
        end
    end

    // lane split, low quotient bits, lane row and column, map bound
    logic [POS_W-1:0] r_lb_p [LANES];
    logic [DIM_W-1:0] r_lb_q [LANES];
    logic [LANES-1:0] r_lb_in;
    t_ctx             r_lb_ctx;
    logic [POS_W-1:0] n_lb_p [LANES];
    logic [DIM_W-1:0] n_lb_q [LANES];
    logic [LANES-1:0] n_lb_in;

    always_comb begin
        logic [DIM_W:0]        v;
        logic [LANE_Q_W-1:0]   k;
        v = '0;
        k = '0;
        for (int i = 0; i < LANES; i++) begin
            v = r_la_v[i];
            k = {r_la_k[i], {(LANE_Q_W-LANE_Q_HI+1){1'b0}}};
            for (int j = LANE_Q_W - LANE_Q_HI; j >= 0; j--) begin
                if ({1'b0, v} >= ({2'b0, r_out_w} << j)) begin
                    v = v - (DIM_W+1)'({2'b0, r_out_w} << j);
                    k[j] = 1'b1;
                end
            end
            n_lb_p[i]  = r_la_p0 + POS_W'(k);
            n_lb_q[i]  = v[DIM_W-1:0];
            n_lb_in[i] = !r_la_ctx.kill
                      && ({r_la_ctx.base[POS_W-1:LANE_W], LANE_W'(i)} < r_la_ctx.total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_LB]) begin
            r_lb_p   <= n_lb_p;
            r_lb_q   <= n_lb_q;
            r_lb_in  <= n_lb_in;
            r_lb_ctx <= r_la_ctx;
        end
    end

    // input coordinates: position times stride plus tap offset
    logic signed [H_W-1:0] r_lc_h [LANES];
    logic signed [W_W-1:0] r_lc_w [LANES];
    logic [LANES-1:0]      r_lc_in;
    logic signed [H_W-1:0] n_lc_h [LANES];
    logic signed [W_W-1:0] n_lc_w [LANES];

    always_comb begin
        logic [POS_W+NIB_W-1:0] ph;
        logic [DIM_W+NIB_W-1:0] pw;
        ph = '0;
        pw = '0;
        for (int i = 0; i < LANES; i++) begin
            ph = (POS_W+NIB_W)'(r_lb_p[i]) * (POS_W+NIB_W)'(r_stride[7:4]);
            pw = (DIM_W+NIB_W)'(r_lb_q[i]) * (DIM_W+NIB_W)'(r_stride[3:0]);
            n_lc_h[i] = $signed({2'b0, ph})
                      + $signed({{(H_W-OFF_W){r_lb_ctx.off_h[OFF_W-1]}}, r_lb_ctx.off_h});
            n_lc_w[i] = $signed({2'b0, pw})
                      + $signed({{(W_W-OFF_W){r_lb_ctx.off_w[OFF_W-1]}}, r_lb_ctx.off_w});
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_LC]) begin
            r_lc_h  <= n_lc_h;
            r_lc_w  <= n_lc_w;
            r_lc_in <= r_lb_in;
        end
    end

    // bounds compare into the output register
    logic [LANES-1:0] r_mask;
    logic [LANES-1:0] n_mask;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_mask[i] = r_lc_in[i]
                     && !r_lc_h[i][H_W-1]
                     && (r_lc_h[i][H_W-2:0] < (H_W-1)'(r_in_h))
                     && !r_lc_w[i][W_W-1]
                     && (r_lc_w[i][W_W-2:0] < (W_W-1)'(r_in_w));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[ST_LD]) begin
            r_mask <= n_mask;
        end
    end

    assign o_valid      = r_v[ST_LD];
    assign o_valid_mask = r_mask;

endmodule

@@ src/cvm_checker.sv @@
// port level checks for the tap valid mask block and their bind
module cvm_checker import cvm_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [LANES-1:0]      o_valid_mask
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_valid_mask))
        else $error("output word changed while stalled");

    // input back-pressure only when the output is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with room in the pipeline");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // a word needs the full pipeline depth after reset before it appears
    a_min_latency: assert property (@(posedge i_clk)
        !i_rst_n |=> ##10 !o_valid)
        else $error("output word earlier than the pipeline depth");

endmodule

bind conv_tap_valid_mask cvm_checker u_cvm_checker (.*);
